// ----- rtl/trap_pkg.sv -----
`timescale 1ns / 1ps

package trap_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned MAG_W      = 31;
  localparam int unsigned DIVISOR_W  = 10;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned QUOT_KEEP  = 17;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = 8;

  localparam logic [DATA_W-1:0] RECIP_NUM    = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_WRAP_LOW = 32'hFFFF_8000;

  typedef struct packed {
    logic             neg;
    logic             zero;
    logic [MAG_W-1:0] mag;
  } mag_word_t;

  typedef struct packed {
    logic                 neg;
    logic                 zero;
    logic [DIVISOR_W-1:0] divisor;
    logic [DIVISOR_W-1:0] rem;
    logic [DATA_W-1:0]    dq;
  } div_word_t;

endpackage

// ----- rtl/trap_prep.sv -----
`timescale 1ns / 1ps

module trap_prep import trap_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output div_word_t         out_word
);

  logic      mag_valid;
  logic      mag_ready;
  mag_word_t mag_word;
  mag_word_t mag_word_next;

  logic         [SHIFT_W-1:0] msb;
  logic         [SHIFT_W-1:0] shift;
  logic         [MAG_W-1:0]   mag_shifted;
  logic         [DATA_W-1:0]  num_shifted;
  div_word_t                  div_next;

  assign in_ready  = !mag_valid || mag_ready;
  assign mag_ready = !out_valid || out_ready;

  // fold the sign into a positive magnitude
  always_comb begin
    mag_word_next.neg  = in_value[DATA_W-1];
    mag_word_next.zero = (in_value == '0);
    if (!in_value[DATA_W-1]) begin
      mag_word_next.mag = in_value[MAG_W-1:0];
    end else if (in_value >= NEG_WRAP_LOW) begin
      mag_word_next.mag = MAG_W'(~in_value + 32'd1);
    end else begin
      mag_word_next.mag = MAG_W'(~in_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (in_ready) begin
      mag_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mag_word <= mag_word_next;
    end
  end

  // keep ten bits from the leading one, shift the numerator to match
  always_comb begin
    msb = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag_word.mag[i]) begin
        msb = SHIFT_W'(i);
      end
    end
    if (msb >= SHIFT_W'(DIVISOR_W)) begin
      shift = msb - SHIFT_W'(DIVISOR_W - 1);
    end else begin
      shift = '0;
    end
    mag_shifted      = mag_word.mag >> shift;
    num_shifted      = RECIP_NUM >> shift;
    div_next.neg     = mag_word.neg;
    div_next.zero    = mag_word.zero;
    div_next.divisor = mag_word.zero ? DIVISOR_W'(1) : mag_shifted[DIVISOR_W-1:0];
    div_next.rem     = '0;
    div_next.dq      = num_shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mag_ready) begin
      out_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mag_ready && mag_valid) begin
      out_word <= div_next;
    end
  end

endmodule

// ----- rtl/trap_div_stage.sv -----
`timescale 1ns / 1ps

module trap_div_stage import trap_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_word_t in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output div_word_t out_word
);

  div_word_t          word_next;
  logic [DIVISOR_W:0] trial;

  assign in_ready = !out_valid || out_ready;

  // restoring division, one quotient bit per step
  always_comb begin
    word_next = in_word;
    trial     = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {word_next.rem, word_next.dq[DATA_W-1]};
      if (trial >= {1'b0, word_next.divisor}) begin
        word_next.rem = DIVISOR_W'(trial - {1'b0, word_next.divisor});
        word_next.dq  = {word_next.dq[DATA_W-2:0], 1'b1};
      end else begin
        word_next.rem = trial[DIVISOR_W-1:0];
        word_next.dq  = {word_next.dq[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.rem < out_word.divisor))
    else $error("remainder not below divisor");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.divisor != '0))
    else $error("zero divisor in flight");

endmodule

// ----- rtl/trap_post.sv -----
`timescale 1ns / 1ps

module trap_post import trap_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  div_word_t         in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_value
);

  logic [SHIFT_W-1:0] msb;
  logic [SHIFT_W-1:0] low;
  logic [DATA_W-1:0]  mask;
  logic [DATA_W-1:0]  kept;
  logic [DATA_W-1:0]  value_next;
  logic               neg;
  logic               zero;

  assign in_ready = !out_valid || out_ready;

  // keep seventeen bits from the leading one, then apply the sign; a zero input gives RECIP_NUM
  always_comb begin
    msb = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (in_word.dq[i]) begin
        msb = SHIFT_W'(i);
      end
    end
    if (msb >= SHIFT_W'(QUOT_KEEP)) begin
      low = msb - SHIFT_W'(QUOT_KEEP - 1);
    end else begin
      low = '0;
    end
    mask = {DATA_W{1'b1}} << low;
    kept = in_word.dq & mask;
    if (in_word.zero) begin
      value_next = RECIP_NUM;
    end else if (in_word.neg) begin
      value_next = ~kept;
    end else begin
      value_next = kept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_value <= value_next;
      neg       <= in_word.neg;
      zero      <= in_word.zero;
    end
  end

  a_sign_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_value[DATA_W-1] == (neg && !zero)))
    else $error("result sign does not follow input sign");

  a_quot_width: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !neg && !zero) |-> ($countones(out_value) <= QUOT_KEEP))
    else $error("quotient keeps too many bits");

endmodule

// ----- rtl/truncated_reciprocal_approx_top.sv -----
`timescale 1ns / 1ps
// An accepted input word passes the prep magnitude and divisor registers, the division stages and the post register.
// Throughput: one word per cycle while the output is not stalled; 32 quotient bits over 8 division stages of 4 steps.
// A stalled output holds its word; upstream stages keep filling any bubbles.
// Reset (rst, synchronous, active high) clears every stage valid bit.

module truncated_reciprocal_approx_top import trap_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic signed [DATA_W-1:0] s_tdata,  // [31:0] w_value
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic signed [DATA_W-1:0] m_tdata   // [31:0] inverse_w
);

  logic      dv [DIV_STAGES+1];
  logic      dr [DIV_STAGES+1];
  div_word_t dw [DIV_STAGES+1];

  logic [DATA_W-1:0] result;

  trap_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_value  (DATA_W'(s_tdata)),
    .out_valid (dv[0]),
    .out_ready (dr[0]),
    .out_word  (dw[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    trap_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[g]),
      .in_ready  (dr[g]),
      .in_word   (dw[g]),
      .out_valid (dv[g+1]),
      .out_ready (dr[g+1]),
      .out_word  (dw[g+1])
    );
  end

  trap_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv[DIV_STAGES]),
    .in_ready  (dr[DIV_STAGES]),
    .in_word   (dw[DIV_STAGES]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (result)
  );

  assign m_tdata = signed'(result);

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import trap_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic signed [DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic signed [DATA_W-1:0] m_tdata;

  logic [DATA_W-1:0] w_words_q[$];
  logic [DATA_W-1:0] recip_q[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit snk_hold = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_neg = 0;
  int unsigned n_wrap = 0;
  int unsigned n_zero = 0;
  int unsigned n_err = 0;

  truncated_reciprocal_approx_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] keep_leading(logic [DATA_W-1:0] v, int keep);
    int msb;
    msb = -1;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (v[i] && msb < 0) msb = i;
    end
    if (msb < keep) return v;
    return v & ({DATA_W{1'b1}} << (msb - keep + 1));
  endfunction

  function automatic logic [DATA_W-1:0] recip_of(logic [DATA_W-1:0] w);
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] q;
    if (w == '0) return RECIP_NUM;
    if (w[DATA_W-1]) mag = (w >= NEG_WRAP_LOW) ? (~w + 1'b1) : ~w;
    else mag = w;
    mag = keep_leading(mag, DIVISOR_W);
    q = RECIP_NUM / mag;
    q = keep_leading(q, QUOT_KEEP);
    return w[DATA_W-1] ? ~q : q;
  endfunction

  function automatic logic [DATA_W-1:0] random_w();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, 31);
      2: v = NEG_WRAP_LOW + $urandom_range(0, 32767);
      3: v = ~($urandom >> $urandom_range(0, 31));
      4: v = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
      default: v = -(32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
    endcase
    return v;
  endfunction

  // drive inputs, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        recip_q.push_back(recip_of(s_tdata));
        n_sent++;
        if (s_tdata == '0) n_zero++;
        if (s_tdata[DATA_W-1]) n_neg++;
        if (s_tdata >= NEG_WRAP_LOW) n_wrap++;
      end
      if (!s_tvalid || s_tready) begin
        if (w_words_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= w_words_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !snk_hold && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (recip_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected word: inverse_w %h", m_tdata);
      end else begin
        logic [DATA_W-1:0] exp_w;
        exp_w = recip_q.pop_front();
        n_checked++;
        if (m_tdata !== exp_w) begin
          n_err++;
          if (n_err <= 10)
            $display("word %0d: inverse_w expected %h, got %h", n_checked, exp_w, m_tdata);
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (n_sent >= 1100);
    @(negedge clk);
    snk_hold = 1'b1;
    repeat (300) @(negedge clk);
    snk_hold = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("truncated_reciprocal_approx_top: mismatch");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] directed[$];
    directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFF,
                 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_8000,
                 32'hFFFF_7FFF, 32'hFFFF_8001, 32'h0000_03FF, 32'h0000_0400,
                 32'h0000_0401, 32'h0000_07FF, 32'h0001_FFFF, 32'h0002_0000,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'h4000_0000, 32'hC000_0000,
                 32'hFFC0_0000, 32'h0000_FFFF};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 17;
          snk_idle_pct = 53;
          foreach (directed[i]) w_words_q.push_back(directed[i]);
        end
        1: begin
          src_idle_pct = 53;
          snk_idle_pct = 17;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      repeat (510) w_words_q.push_back(random_w());
      // hold the sender until every prediction is met
      while (w_words_q.size() != 0 || s_tvalid || recip_q.size() != 0) @(negedge clk);
    end
    repeat (40) @(posedge clk);
    $display("checked %0d reciprocal words: %0d negative (%0d in the negation range), %0d zero",
             n_checked, n_neg, n_wrap, n_zero);
    $display("idling on both sides, a 300-cycle output hold-off, %0d mismatches", n_err);
    if (n_err == 0 && recip_q.size() == 0) begin
      $display("truncated_reciprocal_approx_top: match");
    end else begin
      $display("truncated_reciprocal_approx_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/trap_pkg.sv
rtl/trap_prep.sv
rtl/trap_div_stage.sv
rtl/trap_post.sv
rtl/truncated_reciprocal_approx_top.sv
dv/testbench.sv
